[design/nor_flash_command_sequencer_core_defines.svh]
// ----------------------------------------------------------------------------
// NOR flash command sequencer - assertion macros
// Immediate-antecedent and next-cycle property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef NOR_FLASH_COMMAND_SEQUENCER_CORE_DEFINES_SVH
`define NOR_FLASH_COMMAND_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define NFCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NFCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/nfcs_pkg.sv]
// ----------------------------------------------------------------------------
// NOR flash command sequencer - package
// Shared codes, job and beat types, and the bus-cycle table.
// ----------------------------------------------------------------------------
package nfcs_pkg;

   localparam int ADDR_W              = 19;
   localparam int ADDR_BITS_DEFAULT   = 19;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // host commands
   localparam logic [2:0] CMD_READ   = 3'd0;
   localparam logic [2:0] CMD_PROG   = 3'd1;
   localparam logic [2:0] CMD_CHIP   = 3'd2;
   localparam logic [2:0] CMD_SECTOR = 3'd3;
   localparam logic [2:0] CMD_SAMPLE = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_DATA   = 2'd2;
   localparam logic [1:0] KIND_FINISH = 2'd3;

   // job sequences
   localparam logic [2:0] SEQ_READ   = 3'd0;
   localparam logic [2:0] SEQ_PROG   = 3'd1;
   localparam logic [2:0] SEQ_ERASE  = 3'd2;
   localparam logic [2:0] SEQ_DATA   = 3'd3;
   localparam logic [2:0] SEQ_POLL   = 3'd4;
   localparam logic [2:0] SEQ_FINISH = 3'd5;

   localparam logic [ADDR_W-1:0] ADDR_UNLOCK1 = 19'h00555;
   localparam logic [ADDR_W-1:0] ADDR_UNLOCK2 = 19'h002AA;

   localparam logic [7:0] BYTE_UNLOCK1 = 8'hAA;
   localparam logic [7:0] BYTE_UNLOCK2 = 8'h55;
   localparam logic [7:0] BYTE_PROG    = 8'hA0;
   localparam logic [7:0] BYTE_ERASE   = 8'h80;
   localparam logic [7:0] BYTE_CHIP    = 8'h10;
   localparam logic [7:0] BYTE_SECTOR  = 8'h30;
   localparam logic [7:0] BYTE_RESET   = 8'hF0;
   localparam logic [7:0] DQ6_MASK     = 8'h40;
   localparam logic [7:0] DQ5_MASK     = 8'h20;

   typedef struct packed {
      logic [2:0]        seq;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
      logic              fail;
   } job_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
      logic              failed;
      logic              last;
   } beat_type;

   function automatic beat_type make_beat(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                                          input logic [7:0] data, input logic failed,
                                          input logic last);
      beat_type b;
      b.kind   = kind;
      b.addr   = addr;
      b.data   = data;
      b.failed = failed;
      b.last   = last;
      return b;
   endfunction

   // bus cycle for one step of a job
   function automatic beat_type beat_of(input job_type j, input logic [2:0] step);
      beat_type b;
      b = make_beat(KIND_READ, j.addr, 8'h00, 1'b0, 1'b1);
      case (j.seq)
         SEQ_PROG: begin
            case (step)
               3'd0:    b = make_beat(KIND_WRITE, ADDR_UNLOCK1, BYTE_UNLOCK1, 1'b0, 1'b0);
               3'd1:    b = make_beat(KIND_WRITE, ADDR_UNLOCK2, BYTE_UNLOCK2, 1'b0, 1'b0);
               3'd2:    b = make_beat(KIND_WRITE, ADDR_UNLOCK1, BYTE_PROG, 1'b0, 1'b0);
               3'd3:    b = make_beat(KIND_WRITE, j.addr, j.data, 1'b0, 1'b0);
               default: b = make_beat(KIND_READ, j.addr, 8'h00, 1'b0, 1'b1);
            endcase
         end
         SEQ_ERASE: begin
            case (step)
               3'd0:    b = make_beat(KIND_WRITE, ADDR_UNLOCK1, BYTE_UNLOCK1, 1'b0, 1'b0);
               3'd1:    b = make_beat(KIND_WRITE, ADDR_UNLOCK2, BYTE_UNLOCK2, 1'b0, 1'b0);
               3'd2:    b = make_beat(KIND_WRITE, ADDR_UNLOCK1, BYTE_ERASE, 1'b0, 1'b0);
               3'd3:    b = make_beat(KIND_WRITE, ADDR_UNLOCK1, BYTE_UNLOCK1, 1'b0, 1'b0);
               3'd4:    b = make_beat(KIND_WRITE, ADDR_UNLOCK2, BYTE_UNLOCK2, 1'b0, 1'b0);
               3'd5:    b = make_beat(KIND_WRITE, j.addr, j.data, 1'b0, 1'b0);
               default: b = make_beat(KIND_READ, j.addr, 8'h00, 1'b0, 1'b1);
            endcase
         end
         SEQ_DATA: b = make_beat(KIND_DATA, j.addr, j.data, 1'b0, 1'b1);
         SEQ_FINISH: begin
            if (step == 3'd0) begin
               b = make_beat(KIND_WRITE, j.addr, BYTE_RESET, 1'b0, 1'b0);
            end else begin
               b = make_beat(KIND_FINISH, j.addr, 8'h00, j.fail, 1'b1);
            end
         end
         default: b = make_beat(KIND_READ, j.addr, 8'h00, 1'b0, 1'b1);
      endcase
      return b;
   endfunction

endpackage

[design/nor_flash_command_sequencer_core.sv]
// ----------------------------------------------------------------------------
// NOR flash command sequencer - top level
// Turns host commands and flash data samples into NOR bus cycles and reports.
// ----------------------------------------------------------------------------
// Request side is a queue write port: a beat (req_cmd, req_target_addr,
// req_payload) is taken on a clock edge with push high and full low.
// Result side is a queue read port: while empty is low the oldest result is on
// rsp_*, and it leaves on an edge with pop high. Each request yields 0 to 7
// results; rsp_last_of_run marks the last of them.
// With the job queue and result register empty, a taken request goes into the
// job queue and its first result is then registered and shown on rsp_*.
// Throughput: one result per cycle while results are popped, set by the
// step counter of the bus-cycle generator; a request takes the generator for
// each result (1 to 7); requests with no result cost nothing past the front end.
// Requests are taken every cycle until the job queue (QUEUE_DEPTH jobs) fills.
// A stalled result holds on rsp_* while new requests keep entering the queue.
// Reset empties the queue and result register and returns to idle.
// ----------------------------------------------------------------------------
module nor_flash_command_sequencer_core #(
   parameter int ADDR_BITS   = nfcs_pkg::ADDR_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = nfcs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic [2:0]                  req_cmd,
   input  logic [nfcs_pkg::ADDR_W-1:0] req_target_addr,
   input  logic [7:0]                  req_payload,
   output logic                        empty,
   input  logic                        pop,
   output logic [1:0]                  rsp_cycle_kind,
   output logic [nfcs_pkg::ADDR_W-1:0] rsp_bus_addr,
   output logic [7:0]                  rsp_bus_byte,
   output logic                        rsp_failed,
   output logic                        rsp_last_of_run
);
   import nfcs_pkg::*;

   logic     accept;
   logic     fe_valid;
   job_type  fe_job;
   logic     q_valid;
   job_type  q_job;
   logic     q_pop;
   logic     out_valid;
   beat_type out_beat;

   assign accept = push && !full;

   nfcs_front #(.ADDR_BITS(ADDR_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (req_cmd),
      .target_addr (req_target_addr),
      .payload     (req_payload),
      .job_valid   (fe_valid),
      .job         (fe_job)
   );

   nfcs_job_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (fe_valid),
      .wr_job   (fe_job),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_job   (q_job),
      .full     (full)
   );

   nfcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job       (q_job),
      .job_done  (q_pop),
      .out_valid (out_valid),
      .out_beat  (out_beat),
      .out_take  (pop && out_valid)
   );

   assign empty           = !out_valid;
   assign rsp_cycle_kind  = out_beat.kind;
   assign rsp_bus_addr    = out_beat.addr;
   assign rsp_bus_byte    = out_beat.data;
   assign rsp_failed      = out_beat.failed;
   assign rsp_last_of_run = out_beat.last;

endmodule

[design/nfcs_front.sv]
// ----------------------------------------------------------------------------
// NOR flash command sequencer - front end
// Classifies each accepted beat against the operation state and emits a job when the beat fits that state.
// ----------------------------------------------------------------------------
module nfcs_front #(
   parameter int ADDR_BITS = nfcs_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [2:0]                    cmd,
   input  logic [nfcs_pkg::ADDR_W-1:0]   target_addr,
   input  logic [7:0]                    payload,
   output logic                          job_valid,
   output nfcs_pkg::job_type             job
);
   import nfcs_pkg::*;

   localparam int AW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_READ = 2'd1;
   localparam logic [1:0] PH_POLL = 2'd2;

   logic [1:0]    phase_ff, phase_in;
   logic          prev_ff, prev_in;
   logic          first_ff, first_in;
   logic [AW-1:0] held_ff, held_in;

   logic [AW-1:0] addr_m;
   logic          dq6, dq5, toggling;

   assign addr_m   = target_addr[AW-1:0];
   assign dq6      = |(payload & DQ6_MASK);
   assign dq5      = |(payload & DQ5_MASK);
   assign toggling = dq6 != prev_ff;

   always_comb begin
      phase_in  = phase_ff;
      prev_in   = prev_ff;
      first_in  = first_ff;
      held_in   = held_ff;
      job_valid = 1'b0;
      job.seq   = SEQ_POLL;
      job.addr  = ADDR_W'(held_ff);
      job.data  = payload;
      job.fail  = 1'b0;
      if (accept) begin
         case (cmd)
            CMD_READ, CMD_PROG, CMD_CHIP, CMD_SECTOR: begin
               if (phase_ff == PH_IDLE) begin
                  job_valid = 1'b1;
                  job.addr  = ADDR_W'(addr_m);
                  held_in   = addr_m;
                  if (cmd == CMD_READ) begin
                     job.seq  = SEQ_READ;
                     phase_in = PH_READ;
                  end else begin
                     phase_in = PH_POLL;
                     prev_in  = 1'b0;
                     first_in = 1'b0;
                     if (cmd == CMD_PROG) begin
                        job.seq = SEQ_PROG;
                     end else if (cmd == CMD_CHIP) begin
                        job.seq  = SEQ_ERASE;
                        job.addr = ADDR_UNLOCK1;
                        job.data = BYTE_CHIP;
                        held_in  = AW'(ADDR_UNLOCK1);
                     end else begin
                        job.seq  = SEQ_ERASE;
                        job.data = BYTE_SECTOR;
                     end
                  end
               end
            end
            CMD_SAMPLE: begin
               if (phase_ff == PH_READ) begin
                  job_valid = 1'b1;
                  job.seq   = SEQ_DATA;
                  phase_in  = PH_IDLE;
               end else if (phase_ff == PH_POLL) begin
                  job_valid = 1'b1;
                  prev_in   = dq6;
                  if (!first_ff) begin
                     first_in = 1'b1;
                  end else if (!(toggling && !dq5)) begin
                     job.seq  = SEQ_FINISH;
                     job.fail = dq5 && toggling;
                     first_in = 1'b0;
                     phase_in = PH_IDLE;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         prev_ff  <= 1'b0;
         first_ff <= 1'b0;
         held_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         first_ff <= first_in;
         held_ff  <= held_in;
      end
   end

endmodule

[design/nfcs_job_queue.sv]
// ----------------------------------------------------------------------------
// NOR flash command sequencer - job queue
// Small FIFO of jobs between the front end and the bus-cycle generator.
// ----------------------------------------------------------------------------
module nfcs_job_queue #(
   parameter int DEPTH = nfcs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  nfcs_pkg::job_type wr_job,
   input  logic              rd_en,
   output logic              rd_valid,
   output nfcs_pkg::job_type rd_job,
   output logic              full
);
   import nfcs_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   job_type       slot_ff [DEPTH];
   logic [PW-1:0] wptr_ff, wptr_in;
   logic [PW-1:0] rptr_ff, rptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign rd_valid = count_ff != '0;
   assign full     = count_ff == FULL_CNT;
   assign rd_job   = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (wr_en) begin
         wptr_in = (wptr_ff == LAST_PTR) ? '0 : wptr_ff + 1'b1;
      end
      if (rd_en) begin
         rptr_in = (rptr_ff == LAST_PTR) ? '0 : rptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

[design/nfcs_back.sv]
// ----------------------------------------------------------------------------
// NOR flash command sequencer - bus-cycle generator
// Steps through each job's cycles into a registered result stage.
// ----------------------------------------------------------------------------
module nfcs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  nfcs_pkg::job_type  job,
   output logic               job_done,
   output logic               out_valid,
   output nfcs_pkg::beat_type out_beat,
   input  logic               out_take
);
   import nfcs_pkg::*;

   logic [2:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   beat_type   beat_ff, beat_cur;
   logic       load;

   assign beat_cur  = beat_of(job, step_ff);
   assign load      = job_valid && (!valid_ff || out_take);
   assign job_done  = load && beat_cur.last;
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (out_take) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         step_in  = beat_cur.last ? 3'd0 : step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= beat_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

endmodule

[design/nfcs_checker.sv]
// ----------------------------------------------------------------------------
// NOR flash command sequencer - port checker
// Temporal checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "nor_flash_command_sequencer_core_defines.svh"

module nfcs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        push,
   input logic                        full,
   input logic                        empty,
   input logic                        pop,
   input logic [1:0]                  rsp_cycle_kind,
   input logic [nfcs_pkg::ADDR_W-1:0] rsp_bus_addr,
   input logic [7:0]                  rsp_bus_byte,
   input logic                        rsp_failed,
   input logic                        rsp_last_of_run
);
   import nfcs_pkg::*;

   `NFCS_ASSERT_NOW(a_reset_empty, clock, 1'b0, $past(reset), empty, "results after reset")

   `NFCS_ASSERT_NOW(a_end_last, clock, reset, !empty && (rsp_cycle_kind == KIND_FINISH || rsp_cycle_kind == KIND_DATA), rsp_last_of_run, "finish or data beat not last")

   `NFCS_ASSERT_NOW(a_fail_kind, clock, reset, !empty && rsp_failed, rsp_cycle_kind == KIND_FINISH, "failed flag outside finish")

   `NFCS_ASSERT_NEXT(a_stall_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_cycle_kind) && $stable(rsp_bus_addr) && $stable(rsp_bus_byte) && $stable(rsp_last_of_run), "stalled beat changed")

endmodule

bind nor_flash_command_sequencer_core nfcs_checker u_checker (.*);
